// File: rtl/lba_run_shortcut_table_defines.svh
// ============================================================================
// Assertion macros for the run shortcut table
// Concurrent checks clocked on clk; ASSERT_OFF compiles them away.
// ============================================================================
`ifndef LBA_RUN_SHORTCUT_TABLE_DEFINES_SVH
`define LBA_RUN_SHORTCUT_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
// check out of reset
`define LRST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lrst: assertion failed");
// check that also holds across reset
`define LRST_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lrst: reset assertion failed");
`else
`define LRST_ASSERT(label, prop)
`define LRST_ASSERT_RST(label, prop)
`endif
`endif

// File: rtl/lrst_pkg.sv
// ============================================================================
// Run shortcut table package
// Field widths, operation and error codes, controller/datapath link types.
// ============================================================================
package lrst_pkg;

  localparam int ADDR_BITS_DEF  = 16;
  localparam int SLOT_COUNT_DEF = 64;

  localparam int KIND_W  = 4;
  localparam int SLOT_W  = 6;
  localparam int LEVEL_W = 4;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;
  localparam int ERR_W   = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_RELINK      = 4'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY       = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK_SLOT  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_CHECK_VALS  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_CHECK_LINK  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RELEASE     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SET_COMPACT = 4'd7;
  localparam logic [KIND_W-1:0] KIND_UNLINK      = 4'd8;

  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RING_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NEWER_LOST = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NOT_IN_USE = 2'd3;

  typedef struct packed {
    logic clr_wr;
    logic start;
    logic old_rd;
    logic fire;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
  } dp_stat_t;

endpackage

// File: rtl/lrst_ifs.sv
// ============================================================================
// Run shortcut table channels
// Valid/ready operation and result channels with source and sink modports.
// ============================================================================
interface lrst_in_if #(
  parameter int ADDR_BITS = lrst_pkg::ADDR_BITS_DEF
) ();
  import lrst_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ADDR_BITS-1:0] block_addr;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    src_slot;
  logic                 src_given;
  logic [LEVEL_W-1:0]   level;
  logic [STAMP_W-1:0]   stamp;
  logic                 count_old;
  logic                 flag_value;

  modport source (
    output valid, kind, block_addr, slot, src_slot, src_given, level, stamp,
           count_old, flag_value,
    input  ready
  );
  modport sink (
    input  valid, kind, block_addr, slot, src_slot, src_given, level, stamp,
           count_old, flag_value,
    output ready
  );
endinterface

interface lrst_out_if ();
  import lrst_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [SLOT_W-1:0]  found_slot;
  logic               assigned;
  logic [ERR_W-1:0]   error;
  logic [COUNT_W-1:0] linked_count;
  logic [COUNT_W-1:0] unlinked_count;

  modport source (
    output valid, ok, found_slot, assigned, error, linked_count, unlinked_count,
    input  ready
  );
  modport sink (
    input  valid, ok, found_slot, assigned, error, linked_count, unlinked_count,
    output ready
  );
endinterface

// File: rtl/lrst_ctrl.sv
// ============================================================================
// Run shortcut table controller
// Sequences map clearing, the read phases and the write-back of one beat.
// ============================================================================
`include "lba_run_shortcut_table_defines.svh"

module lrst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lrst_pkg::dp_stat_t stat,
  output lrst_pkg::dp_cmd_t  cmd
);
  import lrst_pkg::*;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_OLD  = 2'd2;
  localparam logic [1:0] ST_EXE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign fire      = (state_r == ST_EXE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (stat.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_OLD;
      ST_OLD:  state_nxt = ST_EXE;
      ST_EXE:  if (fire) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.clr_wr = (state_r == ST_CLR);
    cmd.start  = in_ready && in_valid;
    cmd.old_rd = (state_r == ST_OLD);
    cmd.fire   = fire;
  end

  `LRST_ASSERT(a_no_back_to_back, in_valid && in_ready |=> !in_ready)
  `LRST_ASSERT(a_fire_loads_out, fire |=> out_valid_r)
  `LRST_ASSERT(a_old_then_exe, state_r == ST_OLD |=> state_r == ST_EXE)
  `LRST_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == ST_CLR && !out_valid_r)

endmodule

// File: rtl/lrst_dp.sv
// ============================================================================
// Run shortcut table datapath
// Address map, slot records, free ring, freshness compare and result register.
// ============================================================================
`include "lba_run_shortcut_table_defines.svh"

module lrst_dp #(
  parameter int ADDR_BITS  = lrst_pkg::ADDR_BITS_DEF,
  parameter int SLOT_COUNT = lrst_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lrst_pkg::dp_cmd_t             cmd,
  output lrst_pkg::dp_stat_t            stat,
  input  logic [lrst_pkg::KIND_W-1:0]   kind_i,
  input  logic [ADDR_BITS-1:0]          block_addr_i,
  input  logic [lrst_pkg::SLOT_W-1:0]   slot_i,
  input  logic [lrst_pkg::SLOT_W-1:0]   src_slot_i,
  input  logic                          src_given_i,
  input  logic [lrst_pkg::LEVEL_W-1:0]  level_i,
  input  logic [lrst_pkg::STAMP_W-1:0]  stamp_i,
  input  logic                          count_old_i,
  input  logic                          flag_value_i,
  output logic                          ok_o,
  output logic [lrst_pkg::SLOT_W-1:0]   found_slot_o,
  output logic                          assigned_o,
  output logic [lrst_pkg::ERR_W-1:0]    error_o,
  output logic [lrst_pkg::COUNT_W-1:0]  linked_count_o,
  output logic [lrst_pkg::COUNT_W-1:0]  unlinked_count_o
);
  import lrst_pkg::*;

  localparam int SIW    = $clog2(SLOT_COUNT);
  localparam int CW     = (SIW > SLOT_W) ? SIW : SLOT_W;
  localparam int RCW    = $clog2(SLOT_COUNT + 1);
  localparam int EW     = SIW + 1;
  localparam int META_W = LEVEL_W + STAMP_W;
  localparam longint unsigned MAP_DEPTH = 64'd1 << ADDR_BITS;

  function automatic logic [SIW-1:0] to_idx(logic [SLOT_W-1:0] s);
    logic [CW-1:0] w;
    w = CW'(s);
    return w[SIW-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(logic [SIW-1:0] s);
    logic [CW-1:0] w;
    w = CW'(s);
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic is_newer(logic [LEVEL_W-1:0] la, logic [STAMP_W-1:0] sa,
                                    logic [LEVEL_W-1:0] lb, logic [STAMP_W-1:0] sb);
    logic [STAMP_W-1:0] d;
    d = sa - sb;
    if (la != lb) return la < lb;
    return (d != '0) && !d[STAMP_W-1];
  endfunction

  // storage
  logic [EW-1:0]      map_mem  [0:MAP_DEPTH-1];
  logic [META_W-1:0]  meta_mem [SLOT_COUNT];
  logic [COUNT_W-1:0] lnk_mem  [SLOT_COUNT];
  logic [COUNT_W-1:0] unl_mem  [SLOT_COUNT];
  logic [SIW-1:0]     ring_mem [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] in_use_r, comp_r, meta_vld_r, lnk_vld_r, unl_vld_r, ring_vld_r;
  logic [SIW-1:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [RCW-1:0]        free_cnt_r, free_cnt_nxt;
  logic [STAMP_W-1:0]    next_stamp_r;
  logic [ADDR_BITS-1:0]  clr_cnt_r;

  // latched beat
  logic [KIND_W-1:0]    kind_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SLOT_W-1:0]    slot_r, src_r;
  logic [LEVEL_W-1:0]   lvl_r;
  logic [STAMP_W-1:0]   stp_r;
  logic                 cnt_old_r, flag_r;

  // read data
  logic [EW-1:0]      map_r;
  logic [META_W-1:0]  meta_a_r, meta_b_r, src_meta_r;
  logic               meta_a_v_r, meta_b_v_r;
  logic [COUNT_W-1:0] lnk_a_r, unl_a_r, lnk_b_r, unl_b_r;
  logic               lnk_a_v_r, unl_a_v_r, lnk_b_v_r, unl_b_v_r;
  logic [SIW-1:0]     ring_r;
  logic               ring_v_r;

  // execute
  logic               asg, slot_in_rng, src_in_rng, live_slot, live_src;
  logic               old_use, old_comp, newer, pre_err;
  logic [SIW-1:0]     oidx, sidx, srcidx, start_src, ring_val;
  logic [SLOT_W-1:0]  old_slot, start_slot_src;
  logic [META_W-1:0]  slot_meta, old_meta, cmp_meta;
  logic [COUNT_W-1:0] lnk_a, unl_a, lnk_b, unl_b, lnk_inc, unl_a_inc, unl_b_inc;
  logic               ok_c, asg_c;
  logic [SLOT_W-1:0]  found_c;
  logic [ERR_W-1:0]   err_c;
  logic [COUNT_W-1:0] lnk_c, unl_c;
  logic               do_alloc, do_release, do_compact, do_link, do_unlink, inc_old;
  logic               map_we;
  logic [ADDR_BITS-1:0] map_wa;
  logic [EW-1:0]      map_wd;

  assign start_slot_src = src_given_i ? src_slot_i : slot_i;
  assign start_src      = to_idx(start_slot_src);
  assign stat.clr_done  = &clr_cnt_r;

  assign asg         = map_r[SIW];
  assign oidx        = map_r[SIW-1:0];
  assign old_slot    = asg ? to_slot(oidx) : '0;
  assign sidx        = to_idx(slot_r);
  assign srcidx      = to_idx(src_r);
  assign slot_in_rng = int'(slot_r) < SLOT_COUNT;
  assign src_in_rng  = int'(src_r) < SLOT_COUNT;
  assign live_slot   = slot_in_rng && in_use_r[sidx];
  assign live_src    = src_in_rng && in_use_r[srcidx];
  assign old_use     = asg && in_use_r[oidx];
  assign old_comp    = asg && comp_r[oidx];
  assign pre_err     = !live_slot || (kind_r == KIND_CHECK_LINK && !live_src);
  assign ring_val    = ring_v_r ? ring_r : head_r;

  assign slot_meta = meta_a_v_r ? meta_a_r : '0;
  assign old_meta  = meta_b_v_r ? meta_b_r : '0;
  assign lnk_a     = lnk_a_v_r ? lnk_a_r : '0;
  assign unl_a     = unl_a_v_r ? unl_a_r : '0;
  assign lnk_b     = lnk_b_v_r ? lnk_b_r : '0;
  assign unl_b     = unl_b_v_r ? unl_b_r : '0;
  assign lnk_inc   = lnk_a + 1'b1;
  assign unl_a_inc = unl_a + 1'b1;
  assign unl_b_inc = unl_b + 1'b1;

  always_comb begin
    priority if (kind_r == KIND_CHECK_VALS) begin
      cmp_meta = {lvl_r, stp_r};
    end else if (kind_r == KIND_CHECK_LINK) begin
      cmp_meta = src_meta_r;
    end else begin
      cmp_meta = slot_meta;
    end
  end

  assign newer = is_newer(old_meta[META_W-1:STAMP_W], old_meta[STAMP_W-1:0],
                          cmp_meta[META_W-1:STAMP_W], cmp_meta[STAMP_W-1:0]);

  always_comb begin
    ok_c       = 1'b0;
    found_c    = '0;
    asg_c      = 1'b0;
    err_c      = ERR_NONE;
    lnk_c      = '0;
    unl_c      = '0;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    do_compact = 1'b0;
    do_link    = 1'b0;
    do_unlink  = 1'b0;
    inc_old    = 1'b0;
    unique case (kind_r)
      KIND_ALLOC: begin
        if (free_cnt_r == '0) begin
          err_c = ERR_RING_EMPTY;
        end else begin
          ok_c     = 1'b1;
          found_c  = to_slot(ring_val);
          do_alloc = 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (!live_slot) begin
          err_c = ERR_NOT_IN_USE;
        end else begin
          ok_c       = 1'b1;
          found_c    = slot_r;
          lnk_c      = lnk_a;
          unl_c      = unl_a;
          do_release = 1'b1;
        end
      end
      KIND_SET_COMPACT: begin
        if (!slot_in_rng) begin
          err_c = ERR_NOT_IN_USE;
        end else begin
          ok_c       = 1'b1;
          found_c    = slot_r;
          lnk_c      = lnk_a;
          unl_c      = unl_a;
          do_compact = 1'b1;
        end
      end
      KIND_QUERY: begin
        found_c = old_slot;
        asg_c   = asg;
        ok_c    = old_use;
        if (asg) begin
          lnk_c = lnk_b;
          unl_c = unl_b;
        end
      end
      KIND_RELINK, KIND_CHECK_SLOT, KIND_CHECK_VALS, KIND_CHECK_LINK, KIND_UNLINK: begin
        found_c = old_slot;
        asg_c   = asg;
        if (live_slot) begin
          lnk_c = lnk_a;
          unl_c = unl_a;
        end
        if (pre_err) begin
          err_c = ERR_NOT_IN_USE;
        end else begin
          unique case (kind_r)
            KIND_RELINK: begin
              ok_c    = 1'b1;
              do_link = 1'b1;
              inc_old = old_use && cnt_old_r;
              if (asg && !old_comp && newer) err_c = ERR_NEWER_LOST;
            end
            KIND_CHECK_SLOT: ok_c = !asg || !newer;
            KIND_CHECK_VALS: ok_c = !asg || (oidx == sidx) || !newer;
            KIND_CHECK_LINK: begin
              ok_c    = !asg || old_comp || !newer;
              do_link = ok_c;
              inc_old = ok_c && old_use;
            end
            default: begin
              ok_c      = asg;
              do_unlink = asg;
            end
          endcase
          if (do_link) lnk_c = lnk_inc;
          if (do_unlink || (inc_old && oidx == sidx)) unl_c = unl_a_inc;
        end
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  // map write port: clearing sweep or write-back
  always_comb begin
    map_we = cmd.clr_wr || (cmd.fire && (do_link || do_unlink));
    map_wa = cmd.clr_wr ? clr_cnt_r : addr_r;
    map_wd = (cmd.clr_wr || do_unlink) ? '0 : {1'b1, sidx};
  end

  assign head_nxt     = (head_r == SIW'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
  assign tail_nxt     = (tail_r == SIW'(SLOT_COUNT - 1)) ? '0 : tail_r + 1'b1;
  assign free_cnt_nxt = do_alloc ? free_cnt_r - 1'b1 : free_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd.start) map_r <= map_mem[block_addr_i];
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && do_alloc) meta_mem[ring_val] <= {lvl_r, next_stamp_r};
    if (cmd.start) begin
      meta_a_r   <= meta_mem[to_idx(slot_i)];
      meta_a_v_r <= meta_vld_r[to_idx(slot_i)];
      meta_b_r   <= meta_mem[start_src];
      meta_b_v_r <= meta_vld_r[start_src];
    end else if (cmd.old_rd) begin
      src_meta_r <= meta_b_v_r ? meta_b_r : '0;
      meta_b_r   <= meta_mem[oidx];
      meta_b_v_r <= meta_vld_r[oidx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && do_link) lnk_mem[sidx] <= lnk_inc;
    if (cmd.fire && do_unlink) begin
      unl_mem[sidx] <= unl_a_inc;
    end else if (cmd.fire && inc_old) begin
      unl_mem[oidx] <= unl_b_inc;
    end
    if (cmd.start) begin
      lnk_a_r   <= lnk_mem[to_idx(slot_i)];
      lnk_a_v_r <= lnk_vld_r[to_idx(slot_i)];
      unl_a_r   <= unl_mem[to_idx(slot_i)];
      unl_a_v_r <= unl_vld_r[to_idx(slot_i)];
    end
    if (cmd.old_rd) begin
      lnk_b_r   <= lnk_mem[oidx];
      lnk_b_v_r <= lnk_vld_r[oidx];
      unl_b_r   <= unl_mem[oidx];
      unl_b_v_r <= unl_vld_r[oidx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && do_release) ring_mem[tail_r] <= sidx;
    if (cmd.start) begin
      ring_r   <= ring_mem[head_r];
      ring_v_r <= ring_vld_r[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r    <= kind_i;
      addr_r    <= block_addr_i;
      slot_r    <= slot_i;
      src_r     <= start_slot_src;
      lvl_r     <= level_i;
      stp_r     <= stamp_i;
      cnt_old_r <= count_old_i;
      flag_r    <= flag_value_i;
    end
    if (cmd.fire) begin
      ok_o             <= ok_c;
      found_slot_o     <= found_c;
      assigned_o       <= asg_c;
      error_o          <= err_c;
      linked_count_o   <= lnk_c;
      unlinked_count_o <= unl_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r     <= '0;
      comp_r       <= '0;
      meta_vld_r   <= '0;
      lnk_vld_r    <= '0;
      unl_vld_r    <= '0;
      ring_vld_r   <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      free_cnt_r   <= RCW'(SLOT_COUNT);
      next_stamp_r <= '0;
      clr_cnt_r    <= '0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.fire) begin
        if (do_alloc) begin
          in_use_r[ring_val]   <= 1'b1;
          meta_vld_r[ring_val] <= 1'b1;
          head_r               <= head_nxt;
          free_cnt_r           <= free_cnt_nxt;
          next_stamp_r         <= next_stamp_r + 1'b1;
        end
        if (do_release) begin
          in_use_r[sidx]     <= 1'b0;
          lnk_vld_r[sidx]    <= 1'b0;
          unl_vld_r[sidx]    <= 1'b0;
          ring_vld_r[tail_r] <= 1'b1;
          tail_r             <= tail_nxt;
          free_cnt_r         <= free_cnt_nxt;
        end
        if (do_compact) comp_r[sidx] <= flag_r;
        if (do_link) lnk_vld_r[sidx] <= 1'b1;
        if (do_unlink) begin
          unl_vld_r[sidx] <= 1'b1;
        end else if (inc_old) begin
          unl_vld_r[oidx] <= 1'b1;
        end
      end
    end
  end

  `LRST_ASSERT(a_alloc_takes_slot, cmd.fire && do_alloc |=> free_cnt_r == $past(free_cnt_r) - 1'b1)
  `LRST_ASSERT(a_alloc_slot_free, cmd.fire && do_alloc |-> !in_use_r[ring_val])
  `LRST_ASSERT(a_ring_balance, $countones(in_use_r) + int'(free_cnt_r) == SLOT_COUNT)

endmodule

// File: rtl/lba_run_shortcut_table.sv
// ============================================================================
// Block address to run slot shortcut table
// Map, slot records and free ring behind one operation channel.
// ============================================================================
// Usage: one operation beat enters on in_chan (valid/ready) and produces
// exactly one result beat on out_chan (valid/ready). Operations are alloc,
// relink, query, slot and value checks, check-and-link, release, set
// compaction and unlink, selected by kind.
// Sequencing: a new operation is accepted only in the idle state, after the
// previous one has written back. The steps are set by the address map
// memory and the slot record memories: the first step reads the map entry
// and the slot/source records, the next reads the old owner's record, and
// the last writes everything back and loads the result register.
// Reset: the map is swept to unassigned, one address a cycle, covering all
// 2**ADDR_BITS addresses (65536 by default); in_chan.ready stays low meanwhile.
// Slot records and the free ring come up in their reset state at once.
// Stall: a result waits in the output register while out_chan.ready is low;
// the next operation is still accepted and held before its write-back until
// the output register frees.
module lba_run_shortcut_table #(
  parameter int ADDR_BITS  = lrst_pkg::ADDR_BITS_DEF,
  parameter int SLOT_COUNT = lrst_pkg::SLOT_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lrst_in_if.sink    in_chan,
  lrst_out_if.source out_chan
);
  import lrst_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  lrst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrst_dp #(
    .ADDR_BITS  (ADDR_BITS),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .kind_i           (in_chan.kind),
    .block_addr_i     (in_chan.block_addr),
    .slot_i           (in_chan.slot),
    .src_slot_i       (in_chan.src_slot),
    .src_given_i      (in_chan.src_given),
    .level_i          (in_chan.level),
    .stamp_i          (in_chan.stamp),
    .count_old_i      (in_chan.count_old),
    .flag_value_i     (in_chan.flag_value),
    .ok_o             (out_chan.ok),
    .found_slot_o     (out_chan.found_slot),
    .assigned_o       (out_chan.assigned),
    .error_o          (out_chan.error),
    .linked_count_o   (out_chan.linked_count),
    .unlinked_count_o (out_chan.unlinked_count)
  );

endmodule

// File: bench/tb_lba_run_shortcut_table.sv
// ============================================================================
// Run shortcut table testbench
// Drives operation beats with random gaps and result back-pressure. A shadow
// copy of the map, slot records and free ring predicts each result not given
// by hand, and the results are checked in order. A short directed table comes
// first. Random operations on a small pool of hot addresses follow, with a
// ring exhaust burst, a release sweep over every slot and one full drain.
// ============================================================================
module tb_lba_run_shortcut_table;
  import lrst_pkg::*;

  localparam int SLOTS      = SLOT_COUNT_DEF;
  localparam int ABITS      = ADDR_BITS_DEF;
  localparam int RAND_OPS   = 1000;
  localparam int CYCLE_CAP  = 600000;
  localparam logic [KIND_W-1:0] KIND_UNDEF = 4'hF;
  localparam bit HAND = 1'b1;
  localparam bit CALC = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ABITS-1:0]   block_addr;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  src_slot;
    logic               src_given;
    logic [LEVEL_W-1:0] level;
    logic [STAMP_W-1:0] stamp;
    logic               count_old;
    logic               flag_value;
  } op_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  found_slot;
    logic               assigned;
    logic [ERR_W-1:0]   error;
    logic [COUNT_W-1:0] linked_count;
    logic [COUNT_W-1:0] unlinked_count;
  } res_t;

  typedef struct packed {
    op_t  op;
    bit   hand;
    res_t want;
  } step_row_t;

  logic clk;
  logic rst_n;

  lrst_in_if #(.ADDR_BITS(ABITS)) in_chan ();
  lrst_out_if out_chan ();

  lba_run_shortcut_table #(
    .ADDR_BITS (ABITS),
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // shadow state: map entry 0 is unassigned, else slot + 1
  bit [SLOT_W:0]      map_entry   [0:(1<<ABITS)-1];
  bit [STAMP_W-1:0]   run_stamp   [SLOTS];
  bit [LEVEL_W-1:0]   run_level   [SLOTS];
  bit [COUNT_W-1:0]   run_linked  [SLOTS];
  bit [COUNT_W-1:0]   run_unlinked[SLOTS];
  bit                 run_live    [SLOTS];
  bit                 run_compact [SLOTS];
  bit [SLOT_W-1:0]    free_ring   [SLOTS];
  int                 ring_head;
  int                 ring_tail;
  int                 ring_fill;
  bit [STAMP_W-1:0]   stamp_next;

  res_t               owed_results[$];
  step_row_t          dir_tab[$];
  bit [ABITS-1:0]     hot_addr[16];
  int                 ops_sent;
  int                 results_seen;
  int                 mismatches;
  int                 err_seen[4];
  int                 cycle_count;
  bit                 tx_calm;
  bit                 rx_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit fresher(bit [LEVEL_W-1:0] la, bit [STAMP_W-1:0] sa,
                                 bit [LEVEL_W-1:0] lb, bit [STAMP_W-1:0] sb);
    bit [STAMP_W-1:0] d;
    d = sa - sb;
    if (la != lb) return la < lb;
    return d != 0 && !d[STAMP_W-1];
  endfunction

  function automatic res_t apply_op(op_t op);
    res_t            r;
    bit              asg;
    bit              pass;
    bit              show;
    bit [SLOT_W-1:0] old;
    bit [SLOT_W-1:0] src;
    bit [SLOT_W-1:0] cs;
    bit [SLOT_W-1:0] s;
    r    = '0;
    show = 1'b0;
    cs   = '0;
    asg  = map_entry[op.block_addr] != 0;
    old  = asg ? map_entry[op.block_addr][SLOT_W-1:0] - 1'b1 : '0;
    src  = op.src_given ? op.src_slot : op.slot;
    case (op.kind)
      KIND_ALLOC: begin
        if (ring_fill == 0) begin
          r.error = ERR_RING_EMPTY;
        end else begin
          s = free_ring[ring_head];
          ring_head = (ring_head + 1) % SLOTS;
          ring_fill--;
          run_stamp[s] = stamp_next;
          stamp_next   = stamp_next + 1;
          run_level[s] = op.level;
          run_live[s]  = 1'b1;
          r.ok = 1'b1;
          r.found_slot = s;
          show = 1'b1;
          cs = s;
        end
      end
      KIND_RELEASE: begin
        if (!run_live[op.slot]) begin
          r.error = ERR_NOT_IN_USE;
        end else begin
          r.ok = 1'b1;
          r.found_slot = op.slot;
          r.linked_count = run_linked[op.slot];
          r.unlinked_count = run_unlinked[op.slot];
          run_linked[op.slot] = '0;
          run_unlinked[op.slot] = '0;
          run_live[op.slot] = 1'b0;
          free_ring[ring_tail] = op.slot;
          ring_tail = (ring_tail + 1) % SLOTS;
          ring_fill++;
        end
      end
      KIND_SET_COMPACT: begin
        r.ok = 1'b1;
        r.found_slot = op.slot;
        show = 1'b1;
        cs = op.slot;
        run_compact[op.slot] = op.flag_value;
      end
      KIND_QUERY: begin
        r.found_slot = old;
        r.assigned = asg;
        r.ok = asg && run_live[old];
        show = asg;
        cs = old;
      end
      KIND_RELINK, KIND_CHECK_SLOT, KIND_CHECK_VALS, KIND_CHECK_LINK, KIND_UNLINK: begin
        r.found_slot = old;
        r.assigned = asg;
        if (!run_live[op.slot]) begin
          r.error = ERR_NOT_IN_USE;
        end else begin
          show = 1'b1;
          cs = op.slot;
          if (op.kind == KIND_CHECK_LINK && !run_live[src]) begin
            r.error = ERR_NOT_IN_USE;
          end else begin
            case (op.kind)
              KIND_RELINK: begin
                if (asg && !run_compact[old] && fresher(run_level[old], run_stamp[old],
                    run_level[op.slot], run_stamp[op.slot]))
                  r.error = ERR_NEWER_LOST;
                if (asg && op.count_old && run_live[old])
                  run_unlinked[old] = run_unlinked[old] + 1;
                map_entry[op.block_addr] = {1'b0, op.slot} + 1'b1;
                run_linked[op.slot] = run_linked[op.slot] + 1;
                r.ok = 1'b1;
              end
              KIND_CHECK_SLOT: begin
                r.ok = !asg || !fresher(run_level[old], run_stamp[old],
                                        run_level[op.slot], run_stamp[op.slot]);
              end
              KIND_CHECK_VALS: begin
                r.ok = !asg || old == op.slot ||
                       !fresher(run_level[old], run_stamp[old], op.level, op.stamp);
              end
              KIND_CHECK_LINK: begin
                pass = !asg || run_compact[old] ||
                       !fresher(run_level[old], run_stamp[old], run_level[src], run_stamp[src]);
                if (pass) begin
                  if (asg && run_live[old]) run_unlinked[old] = run_unlinked[old] + 1;
                  map_entry[op.block_addr] = {1'b0, op.slot} + 1'b1;
                  run_linked[op.slot] = run_linked[op.slot] + 1;
                end
                r.ok = pass;
              end
              default: begin
                if (asg) begin
                  run_unlinked[op.slot] = run_unlinked[op.slot] + 1;
                  map_entry[op.block_addr] = '0;
                  r.ok = 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    if (show) begin
      r.linked_count = run_linked[cs];
      r.unlinked_count = run_unlinked[cs];
    end
    return r;
  endfunction

  function automatic op_t mk_op(logic [KIND_W-1:0] kind, logic [ABITS-1:0] addr,
                                int slot, int src, int given, int lvl,
                                logic [STAMP_W-1:0] stamp, int co, int fv);
    op_t op;
    op.kind = kind;
    op.block_addr = addr;
    op.slot = SLOT_W'(slot);
    op.src_slot = SLOT_W'(src);
    op.src_given = 1'(given);
    op.level = LEVEL_W'(lvl);
    op.stamp = stamp;
    op.count_old = 1'(co);
    op.flag_value = 1'(fv);
    return op;
  endfunction

  function automatic res_t mk_res(int ok, int found, int asg, logic [ERR_W-1:0] err);
    res_t r;
    r = '0;
    r.ok = 1'(ok);
    r.found_slot = SLOT_W'(found);
    r.assigned = 1'(asg);
    r.error = err;
    return r;
  endfunction

  function automatic void add_row(op_t op, bit hand, res_t want);
    step_row_t row;
    row.op   = op;
    row.hand = hand;
    row.want = want;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic bit [SLOT_W-1:0] pick_slot();
    bit [SLOT_W-1:0] busy[$];
    for (int i = 0; i < SLOTS; i++)
      if (run_live[i]) busy.insert(busy.size(), SLOT_W'(i));
    if (busy.size() != 0 && $urandom_range(0, 99) < 80)
      return busy[$urandom_range(0, busy.size() - 1)];
    return SLOT_W'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic op_t rand_op();
    op_t             op;
    int              pick;
    bit [SLOT_W-1:0] near;
    op = '0;
    pick = $urandom_range(0, 99);
    if      (pick < 10) op.kind = KIND_ALLOC;
    else if (pick < 30) op.kind = KIND_RELINK;
    else if (pick < 40) op.kind = KIND_QUERY;
    else if (pick < 50) op.kind = KIND_CHECK_SLOT;
    else if (pick < 60) op.kind = KIND_CHECK_VALS;
    else if (pick < 75) op.kind = KIND_CHECK_LINK;
    else if (pick < 85) op.kind = KIND_RELEASE;
    else if (pick < 90) op.kind = KIND_SET_COMPACT;
    else if (pick < 98) op.kind = KIND_UNLINK;
    else op.kind = KIND_W'($urandom_range(9, 15));
    op.block_addr = ($urandom_range(0, 99) < 85) ? hot_addr[$urandom_range(0, 15)]
                                                 : ABITS'($urandom);
    op.slot = pick_slot();
    op.src_slot = pick_slot();
    op.src_given = 1'($urandom_range(0, 1));
    op.count_old = 1'($urandom_range(0, 1));
    op.flag_value = 1'($urandom_range(0, 1));
    near = pick_slot();
    op.level = ($urandom_range(0, 1) == 1) ? run_level[near]
                                           : LEVEL_W'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: op.stamp = run_stamp[near];
      1: op.stamp = run_stamp[near] + 1;
      2: op.stamp = run_stamp[near] - 1;
      3: op.stamp = run_stamp[near] - 32'h7FFF_FFFF;
      4: op.stamp = run_stamp[near] - 32'h8000_0000;
      5: op.stamp = run_stamp[near] - 32'h8000_0001;
      default: op.stamp = $urandom;
    endcase
    return op;
  endfunction

  task automatic send_op(input op_t op, input bit hand, input res_t hand_res);
    int   gap;
    res_t calc;
    if (ops_sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= op.kind;
    in_chan.block_addr <= op.block_addr;
    in_chan.slot       <= op.slot;
    in_chan.src_slot   <= op.src_slot;
    in_chan.src_given  <= op.src_given;
    in_chan.level      <= op.level;
    in_chan.stamp      <= op.stamp;
    in_chan.count_old  <= op.count_old;
    in_chan.flag_value <= op.flag_value;
    do @(posedge clk); while (!in_chan.ready);
    calc = apply_op(op);
    owed_results.insert(owed_results.size(), hand ? hand_res : calc);
    ops_sent++;
  endtask

  // result side: random stall, then take one beat and check it
  initial begin
    int   stall;
    res_t got;
    res_t want;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (results_seen % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      got.ok             = out_chan.ok;
      got.found_slot     = out_chan.found_slot;
      got.assigned       = out_chan.assigned;
      got.error          = out_chan.error;
      got.linked_count   = out_chan.linked_count;
      got.unlinked_count = out_chan.unlinked_count;
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        mismatches++;
      end else begin
        want = owed_results[0];
        owed_results.delete(0);
        err_seen[want.error]++;
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          mismatches++;
        end
        if (got.found_slot !== want.found_slot) begin
          $error("found_slot: expected %0d, got %0d", want.found_slot, got.found_slot);
          mismatches++;
        end
        if (got.assigned !== want.assigned) begin
          $error("assigned: expected %0d, got %0d", want.assigned, got.assigned);
          mismatches++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, got.error);
          mismatches++;
        end
        if (got.linked_count !== want.linked_count) begin
          $error("linked_count: expected %0d, got %0d", want.linked_count, got.linked_count);
          mismatches++;
        end
        if (got.unlinked_count !== want.unlinked_count) begin
          $error("unlinked_count: expected %0d, got %0d",
                 want.unlinked_count, got.unlinked_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    step_row_t row;
    res_t      none;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind = '0;
    in_chan.block_addr = '0;
    in_chan.slot = '0;
    in_chan.src_slot = '0;
    in_chan.src_given = 1'b0;
    in_chan.level = '0;
    in_chan.stamp = '0;
    in_chan.count_old = 1'b0;
    in_chan.flag_value = 1'b0;
    none = '0;
    for (int i = 0; i < SLOTS; i++) free_ring[i] = SLOT_W'(i);
    ring_head = 0;
    ring_tail = 0;
    ring_fill = SLOTS;
    stamp_next = '0;
    for (int i = 0; i < 16; i++) hot_addr[i] = ABITS'($urandom);

    add_row(mk_op(KIND_QUERY, 16'h0000, 0, 0, 0, 0, 0, 0, 0),
            HAND, mk_res(0, 0, 0, ERR_NONE));
    add_row(mk_op(KIND_RELEASE, 16'h0000, 5, 0, 0, 0, 0, 0, 0),
            HAND, mk_res(0, 0, 0, ERR_NOT_IN_USE));
    add_row(mk_op(KIND_RELINK, 16'hFFFF, 63, 0, 0, 0, 0, 1, 0),
            HAND, mk_res(0, 0, 0, ERR_NOT_IN_USE));
    add_row(mk_op(KIND_UNDEF, 16'hFFFF, 63, 63, 1, 15, 32'hFFFF_FFFF, 1, 1),
            HAND, mk_res(0, 0, 0, ERR_NONE));
    add_row(mk_op(KIND_ALLOC, 16'h0000, 0, 0, 0, 15, 0, 0, 0),
            HAND, mk_res(1, 0, 0, ERR_NONE));
    add_row(mk_op(KIND_ALLOC, 16'h0000, 0, 0, 0, 0, 0, 0, 0),
            HAND, mk_res(1, 1, 0, ERR_NONE));
    add_row(mk_op(KIND_ALLOC, 16'h0000, 0, 0, 0, 0, 0, 0, 0),
            HAND, mk_res(1, 2, 0, ERR_NONE));
    add_row(mk_op(KIND_RELINK, 16'hFFFF, 0, 0, 0, 0, 0, 1, 0), CALC, none);
    add_row(mk_op(KIND_RELINK, 16'hFFFF, 1, 0, 0, 0, 0, 1, 0), CALC, none);
    add_row(mk_op(KIND_RELINK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_SET_COMPACT, 16'h0000, 1, 0, 0, 0, 0, 0, 1), CALC, none);
    add_row(mk_op(KIND_RELINK, 16'hFFFF, 1, 0, 0, 0, 0, 1, 0), CALC, none);
    add_row(mk_op(KIND_RELINK, 16'hFFFF, 0, 0, 0, 0, 0, 1, 0), CALC, none);
    add_row(mk_op(KIND_RELINK, 16'h8000, 2, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_CHECK_SLOT, 16'h8000, 1, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_CHECK_SLOT, 16'h8000, 2, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_CHECK_VALS, 16'h8000, 0, 0, 0, 0, 32'h8000_0002, 0, 0),
            CALC, none);
    add_row(mk_op(KIND_CHECK_VALS, 16'h8000, 0, 0, 0, 0, 32'h8000_0003, 0, 0),
            CALC, none);
    add_row(mk_op(KIND_CHECK_LINK, 16'h8000, 0, 1, 1, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_CHECK_LINK, 16'h0001, 1, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_CHECK_LINK, 16'h0001, 1, 40, 1, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_RELEASE, 16'h0000, 2, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_QUERY, 16'h8000, 0, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_RELINK, 16'h8000, 1, 0, 0, 0, 0, 1, 0), CALC, none);
    add_row(mk_op(KIND_UNLINK, 16'h8000, 1, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_UNLINK, 16'h8000, 1, 0, 0, 0, 0, 0, 0), CALC, none);
    add_row(mk_op(KIND_SET_COMPACT, 16'h0000, 63, 0, 0, 0, 0, 0, 0), CALC, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      send_op(row.op, row.hand, row.want);
    end

    while (ops_sent < dir_tab.size() + RAND_OPS) begin
      // drain the ring past empty, then hand every slot back
      if (ops_sent == 300) begin
        repeat (SLOTS + 2)
          send_op(mk_op(KIND_ALLOC, ABITS'($urandom), 0, 0, 0, $urandom_range(0, 15),
                        0, 0, 0),
                  CALC, none);
      end
      if (ops_sent == 500) begin
        for (int s = 0; s < SLOTS; s++)
          send_op(mk_op(KIND_RELEASE, ABITS'($urandom), s, 0, 0, 0, 0, 0, 0), CALC, none);
      end
      if (ops_sent == 700) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
      end
      send_op(rand_op(), CALC, none);
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d operations driven, %0d result beats checked, %0d mismatches",
             ops_sent, results_seen, mismatches);
    $display("error codes seen: none %0d, ring empty %0d, newer lost %0d, not in use %0d",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lrst_pkg.sv
rtl/lrst_ifs.sv
rtl/lrst_ctrl.sv
rtl/lrst_dp.sv
rtl/lba_run_shortcut_table.sv
bench/tb_lba_run_shortcut_table.sv
